FILE: rtl/pstp_pkg.sv
`default_nettype none

package pstp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DocIdW  = 32;
  localparam int unsigned WordW   = 24;
  localparam int unsigned PosW    = 22;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 22;

  // Register map of the configuration port
  localparam logic [CfgIdxW-1:0] RegFormsPresent   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFormMatchEn    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFormValue      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTitlesOnly     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTitleLimit     = 3'd4;

  // Bit of a position word that flags the document's last word
  localparam int unsigned LastBit = 23;

  typedef struct packed {
    logic            forms_present;
    logic            form_match_enable;
    logic [ByteW-1:0] form_value;
    logic            titles_only;
    logic [PosW-1:0] title_limit;
  } cfg_t;

  typedef struct packed {
    logic [DocIdW-1:0] doc_id;
    logic [PosW-1:0]   position;
    logic [ByteW-1:0]  form_code;
    logic              doc_last;
  } ref_t;

  // Drop bit 14 of the raw word and close the gap
  function automatic logic [PosW-1:0] word_position(input logic [WordW-1:0] w);
    return {w[22:15], w[13:0]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pstp_parser.sv
`default_nettype none

module pstp_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [pstp_pkg::ByteW-1:0]  byte_i,
  input  wire pstp_pkg::cfg_t              cfg_i,
  output logic                             emit_o,
  output pstp_pkg::ref_t                   ref_o
);

  typedef enum logic [1:0] {
    PhId   = 2'd0,
    PhWord = 2'd1,
    PhForm = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [pstp_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [pstp_pkg::DocIdW-1:0]     doc_q, doc_d;
  logic [pstp_pkg::WordW-1:0]      word_q, word_d;

  logic                            done;
  logic [pstp_pkg::WordW-1:0]      word_cur;
  logic [pstp_pkg::ByteW-1:0]      form_cur;
  logic [pstp_pkg::PosW-1:0]       pos;
  logic                            last;
  logic                            keep;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    doc_d    = doc_q;
    word_d   = word_q;
    done     = 1'b0;
    word_cur = word_q;
    form_cur = '0;
    unique case (phase_q)
      PhWord: begin
        unique case (idx_q)
          2'd0:    word_d[7:0]   = byte_i;
          2'd1:    word_d[15:8]  = byte_i;
          default: word_d[23:16] = byte_i;
        endcase
        word_cur = word_d;
        if (idx_q >= 2'd2) begin
          idx_d = '0;
          if (cfg_i.forms_present) begin
            phase_d = PhForm;
          end else begin
            done = 1'b1;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      PhForm: begin
        form_cur = byte_i;
        done     = 1'b1;
      end
      default: begin
        // document id bytes, least significant first; unused code acts the same
        doc_d[{idx_q, 3'b000} +: 8] = byte_i;
        if (idx_q == 2'd3) begin
          idx_d   = '0;
          phase_d = PhWord;
        end else begin
          idx_d   = idx_q + 2'd1;
          phase_d = PhId;
        end
      end
    endcase

    pos  = pstp_pkg::word_position(word_cur);
    last = word_cur[pstp_pkg::LastBit];
    keep = !(cfg_i.form_match_enable && (form_cur != cfg_i.form_value));
    if (cfg_i.titles_only) begin
      if (pos > cfg_i.title_limit) keep = 1'b0;
    end else begin
      if (pos <= cfg_i.title_limit) keep = 1'b0;
    end

    if (done) begin
      idx_d   = '0;
      phase_d = last ? PhId : PhWord;
    end
  end

  assign emit_o          = step_i && done && keep;
  assign ref_o.doc_id    = doc_q;
  assign ref_o.position  = pos;
  assign ref_o.form_code = form_cur;
  assign ref_o.doc_last  = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhId;
      idx_q   <= '0;
      doc_q   <= '0;
      word_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      doc_q   <= doc_d;
      word_q  <= word_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pstp_out_reg.sv
`default_nettype none

module pstp_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire pstp_pkg::ref_t data_i,
  input  wire logic           stall_i,
  output logic                ready_o,
  output logic                valid_o,
  output pstp_pkg::ref_t      data_o
);

  logic           valid_q;
  pstp_pkg::ref_t data_q;

  // free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/posting_ref_stream_parser_unit.sv
`default_nettype none

// Posting-list reference parser. Bytes of a posting list enter on the in_*
// channel: per document a 4-byte id (least significant byte first), then
// 3-byte position words, each optionally followed by a form byte
// (forms_present). Bit 23 of a position word closes the document; bit 14 is
// dropped to form the 22-bit position. Each completed word that passes the
// form filter and the title-limit filter leaves on the out_* channel with its
// document id, position, form code and last-word flag. One byte is taken every
// cycle while the output side is not stalled. A byte is held in the input
// register until it steps the parser; when it completes a word that passes
// the filters, its reference is loaded into the output register. The
// result is then visible on out_* and leaves when out_stall_i is low. While
// a result waits on a stalled output, one further byte is still taken into
// the input register. The user must write configuration registers through
// cfg_we_i / cfg_index_i / cfg_data_i only while the block is idle; the block
// does not enforce this. Indexes beyond the register map are ignored.

module posting_ref_stream_parser_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         cfg_we_i,
  input  wire logic [pstp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [pstp_pkg::CfgW-1:0]    cfg_data_i,

  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pstp_pkg::ByteW-1:0]   in_byte_i,

  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [pstp_pkg::DocIdW-1:0]       doc_id_o,
  output logic [pstp_pkg::PosW-1:0]         position_o,
  output logic [pstp_pkg::ByteW-1:0]        form_code_o,
  output logic                              doc_last_o
);

  pstp_pkg::cfg_t                cfg_q;
  logic                          in_valid_q;
  logic [pstp_pkg::ByteW-1:0]    in_byte_q;
  logic                          in_accept;
  logic                          step;
  logic                          out_ready;
  logic                          emit;
  pstp_pkg::ref_t                ref_new;
  pstp_pkg::ref_t                ref_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pstp_pkg::RegFormsPresent: cfg_q.forms_present     <= cfg_data_i[0];
        pstp_pkg::RegFormMatchEn:  cfg_q.form_match_enable <= cfg_data_i[0];
        pstp_pkg::RegFormValue:    cfg_q.form_value        <= cfg_data_i[7:0];
        pstp_pkg::RegTitlesOnly:   cfg_q.titles_only       <= cfg_data_i[0];
        pstp_pkg::RegTitleLimit:   cfg_q.title_limit       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: advance the held byte into the parser when the output
  // register can take whatever it produces
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  pstp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .emit_o (emit),
    .ref_o  (ref_new)
  );

  pstp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .data_i  (ref_new),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .data_o  (ref_out)
  );

  assign doc_id_o    = ref_out.doc_id;
  assign position_o  = ref_out.position;
  assign form_code_o = ref_out.form_code;
  assign doc_last_o  = ref_out.doc_last;

endmodule

`default_nettype wire
